/* rtl/bse_pkg.sv */
package bse_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;

    // source of the word written into the element store
    typedef enum logic [1:0] {
        SRC_IN,
        SRC_HOLD,
        SRC_RD
    } t_wr_src;

    // controller -> datapath commands (addresses travel beside this)
    typedef struct packed {
        logic    wr_en;
        t_wr_src wr_src;
        logic    rd_en;
        logic    hold_ld;
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic gt;   // held word strictly greater than read word (signed)
    } t_dp_stat;

endpackage

/* rtl/bubble_sort_engine_unit.sv */
// Channel   Direction  Handshake             Payload
// input     in         start & !busy         i_value, i_last_in
// result    out        o_valid (one cycle)   o_sorted_value, o_last_out, o_overflow
//
// Load: one word per cycle while busy is low; a word is stored until DEPTH are held.
// Sort: each bubble pass runs prime, hold, n - 1 compares and tail on the
//   single-read, single-write element store; at most n passes, fewer with early exit.
// Emit: n results on consecutive cycles, the first after the tail state, the emit read and the result register.
// Reset is synchronous, active low, and clears count, overflow and the controller.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bubble_sort_engine_unit #(
    parameter int DEPTH = bse_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [bse_pkg::DATA_W-1:0] i_value,
    input  logic                              i_last_in,
    output logic                              o_valid,
    output logic signed [bse_pkg::DATA_W-1:0] o_sorted_value,
    output logic                              o_last_out,
    output logic                              o_overflow
);

    localparam int AW = $clog2(DEPTH);

    bse_pkg::t_dp_cmd  dp_cmd;
    bse_pkg::t_dp_stat dp_stat;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    // controller: load count, pass sequencing, early exit, result strobes
    bse_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_last_in  (i_last_in),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_last_out (o_last_out),
        .o_overflow (o_overflow)
    );

    // datapath: element store, held word, signed comparator
    bse_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (dp_cmd),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .i_value   (i_value),
        .o_stat    (dp_stat),
        .o_rd_data (o_sorted_value)
    );

`ifndef SYNTHESIS
    // results of one set come out back to back
    a_emit_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_out) |=> o_valid)
        else $error("gap inside a result burst");

    // a word that does not end the set leaves the block ready
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_in) |=> !busy)
        else $error("busy after a non-final word");

    // the word ending the set starts the sort
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_in) |=> busy)
        else $error("sort not started after final word");

    // the flagged final result closes the burst
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |=> !o_valid)
        else $error("result after the final one");
`endif

endmodule

/* rtl/bse_datapath.sv */
module bse_datapath #(
    parameter int DEPTH = bse_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  bse_pkg::t_dp_cmd                  i_cmd,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [AW-1:0]                     i_rd_addr,
    input  logic signed [bse_pkg::DATA_W-1:0] i_value,
    output bse_pkg::t_dp_stat                 o_stat,
    output logic signed [bse_pkg::DATA_W-1:0] o_rd_data
);

    logic signed [bse_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [bse_pkg::DATA_W-1:0] r_rd_data;
    logic signed [bse_pkg::DATA_W-1:0] r_hold;
    logic signed [bse_pkg::DATA_W-1:0] wr_data;

    always_comb begin
        unique case (i_cmd.wr_src)
            bse_pkg::SRC_IN:   wr_data = i_value;
            bse_pkg::SRC_HOLD: wr_data = r_hold;
            bse_pkg::SRC_RD:   wr_data = r_rd_data;
            default:           wr_data = i_value;
        endcase
    end

    // single write, single registered read; controller never hits one address twice a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // larger word of the pass so far bubbles forward in r_hold
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_ld) begin
            r_hold <= r_rd_data;
        end
    end

    assign o_stat.gt = (r_hold > r_rd_data);
    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bse_ctrl.sv */
module bse_ctrl #(
    parameter int DEPTH = bse_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_last_in,
    input  bse_pkg::t_dp_stat i_stat,
    output bse_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]     o_wr_addr,
    output logic [AW-1:0]     o_rd_addr,
    output logic              busy,
    output logic              o_valid,
    output logic              o_last_out,
    output logic              o_overflow
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PRIME,
        S_HOLD,
        S_CMP,
        S_TAIL,
        S_EMIT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_swapped, n_swapped;
    logic          r_ovf_flag, n_ovf_flag;
    logic          r_valid, n_valid;
    logic          r_last, n_last;
    logic          r_ovf, n_ovf;

    logic [AW-1:0] last_idx;
    logic          room;
    logic [CW-1:0] cnt_after;

    assign last_idx  = AW'(r_count - CW'(1));
    assign room      = (r_count < CW'(DEPTH));
    assign cnt_after = room ? (r_count + CW'(1)) : r_count;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_swapped  = r_swapped;
        n_ovf_flag = r_ovf_flag;
        n_valid    = 1'b0;
        n_last     = 1'b0;
        n_ovf      = 1'b0;
        o_cmd      = '{wr_en: 1'b0, wr_src: bse_pkg::SRC_IN, rd_en: 1'b0, hold_ld: 1'b0};
        o_wr_addr  = '0;
        o_rd_addr  = '0;

        unique case (r_state)
            S_LOAD: begin
                if (start) begin
                    if (room) begin
                        o_cmd.wr_en = 1'b1;
                        o_wr_addr   = AW'(r_count);
                        n_count     = cnt_after;
                    end else begin
                        n_ovf_flag  = 1'b1;
                    end
                    if (i_last_in) begin
                        n_idx   = '0;
                        n_state = (cnt_after == CW'(1)) ? S_EMIT : S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                o_cmd.rd_en = 1'b1;
                n_swapped   = 1'b0;
                n_state     = S_HOLD;
            end
            S_HOLD: begin
                o_cmd.hold_ld = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_rd_addr     = AW'(1);
                n_idx         = AW'(1);
                n_state       = S_CMP;
            end
            S_CMP: begin
                // write back the smaller of the pair, keep the larger in hold
                o_cmd.wr_en   = 1'b1;
                o_wr_addr     = r_idx - AW'(1);
                o_cmd.wr_src  = i_stat.gt ? bse_pkg::SRC_RD : bse_pkg::SRC_HOLD;
                o_cmd.hold_ld = !i_stat.gt;
                if (i_stat.gt) begin
                    n_swapped = 1'b1;
                end
                if (r_idx == last_idx) begin
                    n_state = S_TAIL;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_idx + AW'(1);
                    n_idx       = r_idx + AW'(1);
                end
            end
            S_TAIL: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = bse_pkg::SRC_HOLD;
                o_wr_addr    = last_idx;
                n_idx        = '0;
                n_state      = r_swapped ? S_PRIME : S_EMIT;
            end
            S_EMIT: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = r_idx;
                n_valid     = 1'b1;
                n_last      = (r_idx == last_idx);
                n_ovf       = r_ovf_flag;
                n_idx       = r_idx + AW'(1);
                if (r_idx == last_idx) begin
                    n_count    = '0;
                    n_ovf_flag = 1'b0;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_idx      <= '0;
            r_swapped  <= 1'b0;
            r_ovf_flag <= 1'b0;
            r_valid    <= 1'b0;
            r_last     <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_swapped  <= n_swapped;
            r_ovf_flag <= n_ovf_flag;
            r_valid    <= n_valid;
            r_last     <= n_last;
            r_ovf      <= n_ovf;
        end
    end

    assign busy       = (r_state != S_LOAD);
    assign o_valid    = r_valid;
    assign o_last_out = r_last;
    assign o_overflow = r_ovf;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

    // Element store size of the engine under test, and the word width.
    localparam int SET_CAP   = bse_pkg::DEPTH_DEF;
    localparam int WORD_W    = bse_pkg::DATA_W;
    // Hard ceiling on the run. The slowest correct run (every word held off by
    // the longest gap, full sets sorted with the full number of passes) sits
    // well under this.
    localparam int CYCLE_CAP = 400000;
    // Settle time once every expected word has arrived.
    localparam int TAIL_WAIT = 300;

    typedef logic signed [WORD_W-1:0] word_t;

    // One word as the result channel should show it.
    typedef struct {
        word_t value;
        logic  last;
        logic  ovf;
    } sorted_word_t;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the set being loaded, sorts it the
    // way the engine must when the closing word arrives, and queues the
    // words that the result channel owes us.
    // ------------------------------------------------------------------
    class sort_scoreboard;
        word_t        held_words[$];
        bit           set_overflowed;
        sorted_word_t due_words[$];
        int           mismatches;

        function new();
            set_overflowed = 1'b0;
            mismatches     = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // Bubble passes with a strict greater-than swap, so equal values keep
        // their arrival order; stop after the first pass with no swap.
        function void sort_and_queue();
            word_t arr[$];
            int    n;
            bit    swapped;
            word_t tmp;
            arr = held_words;
            n   = arr.size();
            for (int pass = 0; pass < n; pass++) begin
                swapped = 1'b0;
                for (int k = 0; k + 1 < n; k++) begin
                    if (arr[k] > arr[k + 1]) begin
                        tmp        = arr[k];
                        arr[k]     = arr[k + 1];
                        arr[k + 1] = tmp;
                        swapped    = 1'b1;
                    end
                end
                if (!swapped) break;
            end
            for (int k = 0; k < n; k++) begin
                due_words.push_back('{arr[k], (k == n - 1), set_overflowed});
            end
        endfunction

        // Input word accepted: store it, or drop it past the store size.
        function void note_word(word_t value, logic last);
            if (held_words.size() < SET_CAP) begin
                held_words.push_back(value);
            end else begin
                set_overflowed = 1'b1;
            end
            if (last) begin
                sort_and_queue();
                held_words.delete();
                set_overflowed = 1'b0;
            end
        endfunction

        function void flag(string what, sorted_word_t exp_w, sorted_word_t got_w);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: expected value %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
                         $realtime, what, exp_w.value, exp_w.last, exp_w.ovf,
                         got_w.value, got_w.last, got_w.ovf);
            end
        endfunction

        // Result word accepted: compare against the oldest one owed.
        function void check_word(word_t value, logic last, logic ovf);
            sorted_word_t got_w;
            sorted_word_t exp_w;
            got_w = '{value, last, ovf};
            if (due_words.size() == 0) begin
                exp_w = '{'x, 1'bx, 1'bx};
                flag("unexpected result", exp_w, got_w);
            end else begin
                exp_w = due_words.pop_front();
                if (got_w.value !== exp_w.value || got_w.last !== exp_w.last ||
                    got_w.ovf !== exp_w.ovf) begin
                    flag("result mismatch", exp_w, got_w);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------
    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    word_t i_value;
    logic  i_last_in;
    logic  o_valid;
    word_t o_sorted_value;
    logic  o_last_out;
    logic  o_overflow;

    always #5 i_clk = ~i_clk;

    bubble_sort_engine_unit #(
        .DEPTH(SET_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .o_sorted_value(o_sorted_value),
        .o_last_out    (o_last_out),
        .o_overflow    (o_overflow)
    );

    sort_scoreboard sb = new();

    // Mirrors start so it is only ever lowered once per time step.
    bit start_up   = 1'b0;
    // Words from random sets of ordinary size; steers the end of the run.
    int small_sent = 0;
    int cycle_cnt  = 0;

    // Result side: the receiver cannot hold off, so every strobe is a word.
    // Sampled at the edge that ends the cycle, so the values are pre-edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_word(o_sorted_value, o_last_out, o_overflow);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // Present one word and hold it until the edge that takes it. busy is
    // read straight after the edge, so it is the value the engine saw.
    task automatic push_word(input word_t value, input logic last);
        start     <= 1'b1;
        i_value   <= value;
        i_last_in <= last;
        start_up   = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_word(value, last);
    endtask

    task automatic drop_start();
        if (start_up) begin
            start    <= 1'b0;
            start_up  = 1'b0;
        end
    endtask

    task automatic idle_for(input int cycles);
        drop_start();
        repeat (cycles) @(posedge i_clk);
    endtask

    // Sender holds back until the engine has delivered everything owed.
    task automatic wait_drained();
        drop_start();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Send a whole set; gaps fall before random words when allowed.
    task automatic send_set(input word_t vals[$], input bit gaps);
        for (int k = 0; k < vals.size(); k++) begin
            if (gaps && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 17));
            push_word(vals[k], (k == vals.size() - 1));
        end
    endtask

    // Value mix: full range, small near zero, the two extremes, a tiny pool so
    // that equal values turn up often, and words of negative sign only.
    function automatic word_t pick_value();
        case ($urandom_range(0, 5))
            0, 1: return word_t'($urandom);
            2:    return word_t'($urandom_range(0, 20)) - 10;
            3:    return ($urandom_range(0, 1)) ? word_t'(32'h7fff_ffff)
                                                : word_t'(32'h8000_0000);
            4:    return word_t'($urandom_range(0, 3)) * 1000 - 1500;
            default: return word_t'({1'b1, 31'($urandom)});
        endcase
    endfunction

    // Random set: plain, already ascending (early exit) or descending.
    function automatic void build_set(input int n, output word_t vals[$]);
        int shape;
        shape = $urandom_range(0, 5);
        vals.delete();
        for (int k = 0; k < n; k++) vals.push_back(pick_value());
        if (shape == 4) vals.sort();
        else if (shape == 5) vals.rsort();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        word_t vals[$];
        int    set_no;
        int    n;
        bit    gaps;

        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_value   <= '0;
        i_last_in <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets. A lone word; the two extremes reversed; mixed
        // signs; an already sorted set (one pass only); a fully reversed
        // set (worst number of passes); repeated values.
        vals = '{word_t'(32'h7fff_ffff)};
        send_set(vals, 1'b0);
        vals = '{word_t'(32'h7fff_ffff), word_t'(32'h8000_0000)};
        send_set(vals, 1'b0);
        vals = '{-1, 0, 1, word_t'(32'h8000_0000), word_t'(32'h7fff_ffff)};
        send_set(vals, 1'b1);
        vals = '{-3, -2, 5, 9};
        send_set(vals, 1'b0);
        vals = '{4, 3, 2, 1, 0, -1};
        send_set(vals, 1'b1);
        vals = '{7, -7, 7, -7, 0};
        send_set(vals, 1'b0);

        // Let everything come back before the random part.
        wait_drained();

        // Random sets, mostly short. A set past the store size (full store
        // sorted, rest dropped) goes in first; the tail of the run has no
        // sender gaps.
        set_no = 0;
        while (small_sent < 20) begin
            if (set_no == 0) begin
                n = SET_CAP + $urandom_range(1, 4);
            end else if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(9, 20);
            end else begin
                n = $urandom_range(1, 8);
            end
            build_set(n, vals);
            // Quiet sets give stretches with no idling at all.
            gaps = (small_sent < 12) && ($urandom_range(0, 2) != 0);
            if (gaps && $urandom_range(0, 4) == 0) wait_drained();
            send_set(vals, gaps);
            if (set_no != 0) small_sent += n;
            set_no++;
        end

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
